FILE: hdl/hdsp_pkg.sv
// Shared types, constants and name tables for the HTTP date string parser.
// No dependencies; imported by every module of the block.
package hdsp_pkg;

    localparam int TOKEN_BUFFER = 20;
    localparam int TLEN_W       = $clog2(TOKEN_BUFFER);
    localparam int NUM_FIELDS   = 7;
    localparam int FIELD_W      = 16;
    localparam int COUNT_W      = 3;
    localparam int OUT_BITS     = NUM_FIELDS * FIELD_W + COUNT_W;
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5a;

    localparam logic [23:0] DAY_NAMES [7] = '{
        "sun", "mon", "tue", "wed", "thu", "fri", "sat"
    };
    localparam logic [23:0] MON_NAMES [12] = '{
        "jan", "feb", "mar", "apr", "may", "jun",
        "jul", "aug", "sep", "oct", "nov", "dec"
    };

    // One character after classification, as it travels through the queue.
    typedef struct packed {
        logic       last;
        logic       stop;
        logic       sep;
        logic       digit;
        logic       ws;
        logic       sign;
        logic       minus;
        logic [3:0] digit_val;
        logic [7:0] lower;
    } hdsp_char_t;

    // Weekday names win over month names; the lowest table entry wins.
    function automatic logic [FIELD_W-1:0] match_name(input logic [23:0] key);
        logic [FIELD_W-1:0] v;
        v = '0;
        for (int i = 11; i >= 0; i--) begin
            if (key == MON_NAMES[i]) begin
                v = FIELD_W'(i + 1);
            end
        end
        for (int i = 6; i >= 0; i--) begin
            if (key == DAY_NAMES[i]) begin
                v = FIELD_W'(i);
            end
        end
        return v;
    endfunction

endpackage

FILE: hdl/hdsp_front.sv
// Input side of the parser: takes stream words and classifies each character.
// Depends on hdsp_pkg; feeds hdsp_queue.
module hdsp_front
    import hdsp_pkg::*;
(
    input  logic       s_valid,
    input  logic [7:0] s_data,
    input  logic       s_last,
    output logic       s_ready,
    input  logic       q_full,
    output logic       q_push,
    output hdsp_char_t q_item
);

    logic [7:0] c;

    assign c       = s_data;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb
    begin
        q_item.last      = s_last;
        q_item.stop      = (c == CH_NUL);
        q_item.sep       = (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_COLON)
                           || (c == CH_LF);
        q_item.digit     = (c >= CH_ZERO) && (c <= CH_NINE);
        q_item.ws        = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
        q_item.sign      = (c == CH_PLUS) || (c == CH_MINUS);
        q_item.minus     = (c == CH_MINUS);
        q_item.digit_val = 4'(c - CH_ZERO);
        q_item.lower     = ((c >= CH_UPA) && (c <= CH_UPZ)) ? (c + 8'd32) : c;
    end

endmodule

FILE: hdl/hdsp_queue.sv
// Two-entry queue of classified characters between front and back.
// Depends on hdsp_pkg.
module hdsp_queue
    import hdsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hdsp_char_t push_item,
    output logic       full,
    output logic       not_empty,
    input  logic       pop,
    output hdsp_char_t head
);

    hdsp_char_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: hdl/hdsp_back.sv
// Token engine: accumulates tokens, fills the seven date fields and holds
// the result word for the output stream. Depends on hdsp_pkg.
module hdsp_back
    import hdsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  hdsp_char_t       q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_DONE} phase_t;

    logic [FIELD_W-1:0] field_reg  [NUM_FIELDS];
    logic [FIELD_W-1:0] field_next [NUM_FIELDS];
    logic [2:0]         index_reg, index_next;
    logic [TLEN_W-1:0]  tlen_reg, tlen_next;
    logic               has_digit_reg, has_digit_next;
    logic [7:0]         name_reg  [3];
    logic [7:0]         name_next [3];
    phase_t             phase_reg, phase_next;
    logic [FIELD_W-1:0] num_reg, num_next;
    logic               neg_reg, neg_next;
    logic               stopped_reg, stopped_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    hdsp_char_t         ch;
    logic               active;
    logic               take_digit;
    logic [FIELD_W-1:0] token_value;
    logic [OUT_W-1:0]   result;

    assign ch        = q_head;
    assign q_pop     = q_not_empty && !(ch.last && out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        field_next     = field_reg;
        index_next     = index_reg;
        tlen_next      = tlen_reg;
        has_digit_next = has_digit_reg;
        name_next      = name_reg;
        phase_next     = phase_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        stopped_next   = stopped_reg || ch.stop;
        active         = !stopped_next && (index_reg < 3'(NUM_FIELDS));
        take_digit     = 1'b0;
        result         = '0;

        if (has_digit_reg)
        begin
            token_value = neg_reg ? (~num_reg + 16'd1) : num_reg;
        end
        else if (tlen_reg == TLEN_W'(3))
        begin
            token_value = match_name({name_reg[0], name_reg[1], name_reg[2]});
        end
        else
        begin
            token_value = '0;
        end

        if (active)
        begin
            if (ch.sep)
            begin
                if (tlen_reg != '0)
                begin
                    for (int i = 0; i < NUM_FIELDS; i++)
                    begin
                        if (index_reg == 3'(i))
                        begin
                            field_next[i] = token_value;
                        end
                    end
                    index_next = index_reg + 3'd1;
                end
                tlen_next      = '0;
                has_digit_next = 1'b0;
                name_next      = '{default: 8'd0};
                phase_next     = PH_LEAD;
                num_next       = '0;
                neg_next       = 1'b0;
            end
            else if (tlen_reg < TLEN_W'(TOKEN_BUFFER - 1))
            begin
                if (ch.digit)
                begin
                    has_digit_next = 1'b1;
                end
                if (tlen_reg < TLEN_W'(3))
                begin
                    name_next[tlen_reg[1:0]] = ch.lower;
                end
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (ch.sign)
                        begin
                            neg_next   = ch.minus;
                            phase_next = PH_DIGITS;
                        end
                        else if (!ch.ws)
                        begin
                            take_digit = 1'b1;
                        end
                    end
                    PH_DIGITS:
                    begin
                        take_digit = 1'b1;
                    end
                    default:
                    begin
                        take_digit = 1'b0;
                    end
                endcase
                if (take_digit)
                begin
                    if (ch.digit)
                    begin
                        num_next   = (num_reg << 3) + (num_reg << 1)
                                     + FIELD_W'(ch.digit_val);
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                tlen_next = tlen_reg + TLEN_W'(1);
            end
        end

        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            result[i*FIELD_W +: FIELD_W] = field_next[i];
        end
        result[NUM_FIELDS*FIELD_W +: COUNT_W] = index_next;

        // End of string: the result word is taken and the engine starts over.
        if (ch.last)
        begin
            field_next     = '{default: '0};
            index_next     = '0;
            tlen_next      = '0;
            has_digit_next = 1'b0;
            name_next      = '{default: 8'd0};
            phase_next     = PH_LEAD;
            num_next       = '0;
            neg_next       = 1'b0;
            stopped_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg     <= '{default: '0};
            index_reg     <= '0;
            tlen_reg      <= '0;
            has_digit_reg <= 1'b0;
            name_reg      <= '{default: 8'd0};
            phase_reg     <= PH_LEAD;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                field_reg     <= field_next;
                index_reg     <= index_next;
                tlen_reg      <= tlen_next;
                has_digit_reg <= has_digit_next;
                name_reg      <= name_next;
                phase_reg     <= phase_next;
                num_reg       <= num_next;
                neg_reg       <= neg_next;
                stopped_reg   <= stopped_next;
            end
            if (q_pop && ch.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && ch.last)
        begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: hdl/http_date_string_parser.sv
// HTTP date string parser: one character per word in, one result word per string out.
// The result word is registered when the back end takes the last character from the queue.
// Throughput: one character per cycle, one token step each, while s_axis_tready is high.
// A new string may stream in while the previous result still waits to be taken.
// Reset (rst_n, asynchronous, active low) empties the queue and clears all fields.
// Depends on hdsp_pkg, hdsp_front, hdsp_queue and hdsp_back.
module http_date_string_parser
    import hdsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] char_in
    input  logic             s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // weekday, day, month, year, hour, minute,
                                             // second (16 bits each), fields_found (3 bits),
                                             // zero padding
);

    // The front classifies each character (separator, digit, sign, whitespace,
    // stop byte, lower-case form) and pushes it into a short queue.
    hdsp_char_t push_item;
    hdsp_char_t head_item;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;

    hdsp_front u_front (
        .s_valid (s_axis_tvalid),
        .s_data  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .q_full  (q_full),
        .q_push  (push),
        .q_item  (push_item)
    );

    // The queue lets the input keep streaming while the back end waits for
    // the output side to take a finished result.
    hdsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head      (head_item)
    );

    // The back end builds tokens, stores the fields and registers the result.
    // It stalls only on the last character of a string while the previous
    // result is still held in the output register.
    hdsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (head_item),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule
